### design/ogsb_pkg.sv
// Shared constants, types and tap weighting for the occupancy grid blur.
package ogsb_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIM_W       = 7;   // grid width / height register
  localparam int POS_W       = 6;   // border line coordinates, row/col counters
  localparam int VAL_W       = 16;  // cell value
  localparam int TAPS        = 7;
  localparam int TAP_K_W     = 3;
  localparam int TAP_W       = 19;  // weighted tap, up to 6 * 65535
  localparam int ACC_W       = 21;  // up to 20 * 65535
  localparam int QUART_W     = ACC_W - 2;
  localparam int PROD_W      = 2 * QUART_W;
  localparam int RECIP_SHIFT = 21;
  localparam int NORM_W      = PROD_W - RECIP_SHIFT;

  localparam logic [VAL_W-1:0]   PAD_VALUE  = 16'h8000;
  localparam logic [VAL_W-1:0]   VAL_MAX    = 16'hFFFF;
  localparam logic [ACC_W-1:0]   ROUND_BIAS = 21'd10;
  // ceil(2^21 / 5): exact quotient by 5 for inputs below 699050
  localparam logic [QUART_W-1:0] RECIP      = 19'd419431;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  // func selector
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_PROCESS = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // reply kind
  localparam logic REPLY_READ = 1'b0;
  localparam logic REPLY_DONE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_BOT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_TOP   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAP,
    ST_LAST,
    ST_NORM,
    ST_WRITE,
    ST_BCOL,
    ST_BROW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               clear;
    logic               accum;
    logic               pad;
    logic [TAP_K_W-1:0] k;
    logic               norm;
  } tap_ctrl_t;

  // tap value times its weight (1,2,4,6,4,2,1 in twentieths)
  function automatic logic [TAP_W-1:0] tap_weighted(input logic [VAL_W-1:0] v,
                                                    input logic [TAP_K_W-1:0] k);
    logic [TAP_W-1:0] x;
    logic [TAP_W-1:0] y;
    x = TAP_W'(v);
    case (k) inside
      3'd0, 3'd6: y = x;
      3'd1, 3'd5: y = x << 1;
      3'd2, 3'd4: y = x << 2;
      3'd3:       y = (x << 2) + (x << 1);
      default:    y = '0;
    endcase
    return y;
  endfunction

endpackage

### design/ogsb_tap_unit.sv
// Shared weighted accumulator and divide-by-20 normalizer for both blur passes.
module ogsb_tap_unit (
  input  logic                         clk,
  input  ogsb_pkg::tap_ctrl_t          ctrl,
  input  logic [ogsb_pkg::VAL_W-1:0]   tap_data,
  output logic [ogsb_pkg::VAL_W-1:0]   result
);
  import ogsb_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [NORM_W-1:0]  quot;
  logic [VAL_W-1:0]   tap_val;
  logic [ACC_W-1:0]   biased;
  logic [QUART_W-1:0] quarter;
  logic [PROD_W-1:0]  prod;

  assign tap_val = ctrl.pad ? PAD_VALUE : tap_data;

  // floor((S + 10) / 20) = floor(floor((S + 10) / 4) / 5)
  assign biased  = acc + ROUND_BIAS;
  assign quarter = biased[ACC_W-1:2];
  assign prod    = PROD_W'(quarter) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.accum) begin
      acc <= acc + ACC_W'(tap_weighted(tap_val, ctrl.k));
    end
    if (ctrl.norm) begin
      quot <= prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  assign result = (quot > NORM_W'(VAL_MAX)) ? VAL_MAX : quot[VAL_W-1:0];

endmodule

### design/occupancy_grid_separable_blur.sv
// Top level: occupancy grid store with in-place separable 7-tap blur and border clear.
//
// Holds a 64 x 64 grid of unsigned Q0.16 cells, column-major at row + col * height.
// tuser selects the function: load writes one cell, read returns one cell, process
// blurs the whole grid in place, lowering cells only, and zeroes the mission border, then returns a
// "process finished" reply. Loads may stream back to back, one per cycle, while the
// result stream does not hold a reply back; the input is not ready in the cycle after
// a read is taken, while the grid RAM's registered read port returns the data. Process is sequenced
// through one shared multiply-accumulate unit fed by one RAM read port per cycle:
// each cell of each pass goes through setup, 7 tap steps, drain, normalize and
// write; then the cells of both border columns and both border rows that lie in
// the grid are cleared, one per step. The input is not ready during a process. Both
// RAMs are undefined after reset and need no clearing pass; every cell in use must
// be loaded before a process. Configuration must be written only while the block is
// idle; the block itself does not enforce it.
module occupancy_grid_separable_blur (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ogsb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [11:0] cell_index, [27:12] cell_value
  input  logic [ogsb_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [1:0] func
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ogsb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [15:0] read_value
  output logic [0:0]                          m_axis_tuser,  // [0] reply_kind
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ogsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogsb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ogsb_pkg::*;

  state_t state, state_next;

  // configuration
  logic [DIM_W-1:0] grid_width, grid_height;
  logic [POS_W-1:0] border_left_col, border_right_col;
  logic [POS_W-1:0] border_bottom_row, border_top_row;
  logic [DIM_W-1:0] w_eff, h_eff;

  // input fields
  logic [1:0]        in_func;
  logic [ADDR_W-1:0] in_index;
  logic [VAL_W-1:0]  in_value;
  logic              in_fire;

  // sweep counters
  logic [POS_W-1:0]        row, col;
  logic [ADDR_W-1:0]       cell_addr;
  logic                    pass_v;     // 0 horizontal, 1 vertical
  logic [TAP_K_W-1:0]      tap_k;
  logic signed [POS_W+1:0] tap_pos;
  logic [ADDR_W-1:0]       tap_addr;
  logic                    tap_valid_q, tap_pad_q;
  logic [TAP_K_W-1:0]      tap_k_q;
  logic [DIM_W-1:0]        bidx;
  logic                    bside;

  // result register
  logic             rd_pending;
  logic             out_valid;
  logic             out_kind;
  logic [VAL_W-1:0] out_value;

  // memories
  logic [VAL_W-1:0]  grid_mem [STORE_DEPTH];
  logic [VAL_W-1:0]  blur_mem [STORE_DEPTH];
  logic              grid_we, grid_re, blur_we, blur_re;
  logic [ADDR_W-1:0] grid_waddr, grid_raddr, blur_waddr, blur_raddr;
  logic [VAL_W-1:0]  grid_wdata, blur_wdata;
  logic [VAL_W-1:0]  grid_rdata, blur_rdata;

  // datapath helpers
  logic [DIM_W-1:0]        lim;
  logic [ADDR_W-1:0]       step;
  logic                    tap_in;
  logic                    last_row, last_col;
  logic signed [POS_W+1:0] setup_pos;
  logic [ADDR_W-1:0]       setup_addr;
  logic [POS_W-1:0]        b_row, b_col;
  logic [ADDR_W:0]         b_prod;
  logic [ADDR_W-1:0]       b_addr;
  logic                    b_in, bcol_go, brow_go;
  logic [VAL_W-1:0]        blurred;
  tap_ctrl_t               tap_ctrl;

  assign in_func  = s_axis_tuser;
  assign in_index = s_axis_tdata[ADDR_W-1:0];
  assign in_value = s_axis_tdata[ADDR_W+VAL_W-1:ADDR_W];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width        <= DIM_W'(MAX_WIDTH);
      grid_height       <= DIM_W'(MAX_HEIGHT);
      border_left_col   <= '0;
      border_right_col  <= POS_W'(MAX_WIDTH - 1);
      border_bottom_row <= '0;
      border_top_row    <= POS_W'(MAX_HEIGHT - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:   grid_width        <= cfg_wdata;
        CFG_GRID_HEIGHT:  grid_height       <= cfg_wdata;
        CFG_BORDER_LEFT:  border_left_col   <= cfg_wdata[POS_W-1:0];
        CFG_BORDER_RIGHT: border_right_col  <= cfg_wdata[POS_W-1:0];
        CFG_BORDER_BOT:   border_bottom_row <= cfg_wdata[POS_W-1:0];
        CFG_BORDER_TOP:   border_top_row    <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // oversize grid is clamped to the store
  assign w_eff = (grid_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : grid_width;
  assign h_eff = (grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height;

  // ---------------------------------------------------------------- tap addressing
  // Horizontal taps step one column (height entries), vertical taps one row.
  assign lim        = pass_v ? h_eff : w_eff;
  assign step       = pass_v ? ADDR_W'(1) : ADDR_W'(h_eff);
  assign tap_in     = (tap_pos >= 0) && (tap_pos < $signed({1'b0, lim}));
  assign last_row   = ({1'b0, row} == h_eff - 7'd1);
  assign last_col   = ({1'b0, col} == w_eff - 7'd1);
  assign setup_pos  = $signed({2'b00, (pass_v ? row : col)}) - 8'sd3;
  // tap address may wrap below zero; it is only used once the tap is inside the grid
  assign setup_addr = cell_addr - (pass_v ? ADDR_W'(3)
                                          : ADDR_W'({h_eff, 1'b0}) + ADDR_W'(h_eff));

  // ---------------------------------------------------------------- border clear
  // Column lines first (rows bottom..top), then row lines (cols left+1..right-1).
  always_comb begin
    if (state == ST_BROW) begin
      b_row = bside ? border_top_row : border_bottom_row;
      b_col = bidx[POS_W-1:0];
    end else begin
      b_row = bidx[POS_W-1:0];
      b_col = bside ? border_right_col : border_left_col;
    end
  end

  assign bcol_go = (bidx <= {1'b0, border_top_row});
  assign brow_go = (bidx < {1'b0, border_right_col});
  assign b_in    = ({1'b0, b_row} < h_eff) && ({1'b0, b_col} < w_eff);
  assign b_prod  = (ADDR_W+1)'(b_col) * (ADDR_W+1)'(h_eff);
  assign b_addr  = ADDR_W'(b_row) + b_prod[ADDR_W-1:0];

  // ---------------------------------------------------------------- shared unit
  ogsb_tap_unit u_tap (
    .clk      (clk),
    .ctrl     (tap_ctrl),
    .tap_data (pass_v ? blur_rdata : grid_rdata),
    .result   (blurred)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_PROCESS) begin
          state_next = (w_eff == '0 || h_eff == '0) ? ST_BCOL : ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_TAP;
      ST_TAP: begin
        if (tap_k == TAP_K_W'(TAPS - 1)) state_next = ST_LAST;
      end
      ST_LAST:  state_next = ST_NORM;
      ST_NORM:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (last_row && last_col && pass_v) state_next = ST_BCOL;
        else                                state_next = ST_SETUP;
      end
      ST_BCOL: begin
        if (!bcol_go) state_next = ST_BROW;
      end
      ST_BROW: begin
        if (!brow_go) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------- outputs / controls
  always_comb begin
    s_axis_tready  = (state == ST_IDLE) && !rd_pending && (!out_valid || m_axis_tready);
    grid_we        = 1'b0;
    grid_waddr     = cell_addr;
    grid_wdata     = blurred;
    grid_re        = 1'b0;
    grid_raddr     = tap_addr;
    blur_we        = 1'b0;
    blur_waddr     = cell_addr;
    blur_wdata     = blurred;
    blur_re        = 1'b0;
    blur_raddr     = tap_addr;
    tap_ctrl.clear = 1'b0;
    tap_ctrl.accum = tap_valid_q;
    tap_ctrl.pad   = tap_pad_q;
    tap_ctrl.k     = tap_k_q;
    tap_ctrl.norm  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_LOAD) begin
          grid_we    = 1'b1;
          grid_waddr = in_index;
          grid_wdata = in_value;
        end
        if (in_fire && in_func == FUNC_READ) begin
          grid_re    = 1'b1;
          grid_raddr = in_index;
        end
      end
      ST_TAP: begin
        tap_ctrl.clear = (tap_k == '0);
        if (pass_v) begin
          blur_re = tap_in;
          // vertical pass fetches the cell's own value for the keep-lower test
          if (tap_k == '0) begin
            grid_re    = 1'b1;
            grid_raddr = cell_addr;
          end
        end else begin
          grid_re = tap_in;
        end
      end
      ST_NORM: tap_ctrl.norm = 1'b1;
      ST_WRITE: begin
        if (pass_v) grid_we = (blurred < grid_rdata);
        else        blur_we = 1'b1;
      end
      ST_BCOL, ST_BROW: begin
        grid_we    = ((state == ST_BCOL) ? bcol_go : brow_go) && b_in;
        grid_waddr = b_addr;
        grid_wdata = '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (grid_re) grid_rdata <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (blur_we) blur_mem[blur_waddr] <= blur_wdata;
    if (blur_re) blur_rdata <= blur_mem[blur_raddr];
  end

  // ---------------------------------------------------------------- sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_k       <= '0;
      tap_valid_q <= 1'b0;
    end else begin
      tap_valid_q <= (state == ST_TAP);
      if (state == ST_SETUP) begin
        tap_k <= '0;
      end else if (state == ST_TAP) begin
        tap_k <= (tap_k == TAP_K_W'(TAPS - 1)) ? '0 : tap_k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_pad_q <= !tap_in;
    tap_k_q   <= tap_k;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_PROCESS) begin
          row       <= '0;
          col       <= '0;
          cell_addr <= '0;
          pass_v    <= 1'b0;
          bidx      <= {1'b0, border_bottom_row};
          bside     <= 1'b0;
        end
      end
      ST_SETUP: begin
        tap_pos  <= setup_pos;
        tap_addr <= setup_addr;
      end
      ST_TAP: begin
        tap_pos  <= tap_pos + 8'sd1;
        tap_addr <= tap_addr + step;
      end
      ST_WRITE: begin
        // cells are visited in store order, so the address just counts up
        if (last_row) begin
          row <= '0;
          if (last_col) begin
            col       <= '0;
            cell_addr <= '0;
            pass_v    <= 1'b1;
            bidx      <= {1'b0, border_bottom_row};
            bside     <= 1'b0;
          end else begin
            col       <= col + 6'd1;
            cell_addr <= cell_addr + 12'd1;
          end
        end else begin
          row       <= row + 6'd1;
          cell_addr <= cell_addr + 12'd1;
        end
      end
      ST_BCOL: begin
        if (!bcol_go) begin
          bidx  <= {1'b0, border_left_col} + 7'd1;
          bside <= 1'b0;
        end else begin
          bside <= ~bside;
          if (bside) bidx <= bidx + 7'd1;
        end
      end
      ST_BROW: begin
        if (brow_go) begin
          bside <= ~bside;
          if (bside) bidx <= bidx + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= in_fire && (in_func == FUNC_READ);
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (rd_pending) begin
        out_valid <= 1'b1;
        out_kind  <= REPLY_READ;
        out_value <= grid_rdata;
      end else if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
        out_kind  <= REPLY_DONE;
        out_value <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_kind;

  // ---------------------------------------------------------------- assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_one_store_write: assert property (@(posedge clk) disable iff (rst)
    !(grid_we && blur_we))
    else $error("both stores written in one cycle");

  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_DONE) |-> !out_valid)
    else $error("result pending during process");

  a_read_from_idle: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> $past(state == ST_IDLE))
    else $error("read data pending without idle accept");

  a_tap_count: assert property (@(posedge clk) disable iff (rst)
    (state != ST_TAP) |-> tap_k == '0)
    else $error("tap counter not rewound");

endmodule

### sim/occupancy_grid_separable_blur_tb.sv
// Self-checking testbench for the occupancy grid blur: stream stimulus, shadow grid, reply checks.
`timescale 1ns / 100ps

module occupancy_grid_separable_blur_tb;
  import ogsb_pkg::*;

  // func code the block must drop without a reply
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  localparam int TARGET_ITEMS  = 1450;
  // loads give no reply and a read holds the input only until its data returns, so
  // by the end of the settle wait after the last reply the block is surely back in idle
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 1500000;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } reply_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [11:0] cell_index, [27:12] cell_value
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // [1:0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] read_value
  logic [0:0]             m_axis_tuser;   // [0] reply_kind
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  occupancy_grid_separable_blur u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: grid, row-blur buffer and registers.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] shadow_grid    [0:STORE_DEPTH-1];
  logic [VAL_W-1:0] shadow_rowblur [0:STORE_DEPTH-1];
  int unsigned      shadow_width;
  int unsigned      shadow_height;
  int unsigned      shadow_left;
  int unsigned      shadow_right;
  int unsigned      shadow_bottom;
  int unsigned      shadow_top;

  // cells written so far; a read or a blur never touches any other cell
  bit               cell_loaded [0:STORE_DEPTH-1];
  int               loaded_cells[$];

  reply_t           pending_replies[$];
  reply_t           head_reply;
  int               errors;
  int               items_sent;
  int               cycles;
  bit               calm_sender;
  bit               calm_receiver;

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Blur arithmetic: weights 1,2,4,6,4,2,1 in twentieths, round half up.
  // ---------------------------------------------------------------------------
  function automatic int unsigned blur_weight(input int k);
    case (k)
      0, 6:    return 1;
      1, 5:    return 2;
      2, 4:    return 4;
      default: return 6;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] round_twentieths(input int unsigned sum);
    int unsigned q;
    q = (sum + 10) / 20;
    return (q > 65535) ? 16'hFFFF : q[VAL_W-1:0];
  endfunction

  task automatic clear_shadow_cell(input int r, input int c, input int w, input int h);
    if (r < h && c < w)
      shadow_grid[r + c * h] = '0;
  endtask

  // Horizontal pass into the row buffer, vertical pass back into the grid
  // (only where lower), then the mission border lines.
  task automatic blur_and_clear_shadow();
    int          w;
    int          h;
    int          r;
    int          c;
    int          k;
    int          t;
    int unsigned sum;
    int unsigned tap;
    logic [VAL_W-1:0] blurred;
    w = (shadow_width  > MAX_WIDTH)  ? MAX_WIDTH  : int'(shadow_width);
    h = (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_height);
    for (c = 0; c < w; c++) begin
      for (r = 0; r < h; r++) begin
        sum = 0;
        for (k = 0; k < TAPS; k++) begin
          t   = c + k - 3;
          tap = (t >= 0 && t < w) ? shadow_grid[r + t * h] : PAD_VALUE;
          sum += blur_weight(k) * tap;
        end
        shadow_rowblur[r + c * h] = round_twentieths(sum);
      end
    end
    for (c = 0; c < w; c++) begin
      for (r = 0; r < h; r++) begin
        sum = 0;
        for (k = 0; k < TAPS; k++) begin
          t   = r + k - 3;
          tap = (t >= 0 && t < h) ? shadow_rowblur[t + c * h] : PAD_VALUE;
          sum += blur_weight(k) * tap;
        end
        blurred = round_twentieths(sum);
        if (blurred < shadow_grid[r + c * h])
          shadow_grid[r + c * h] = blurred;
      end
    end
    for (r = int'(shadow_bottom); r <= int'(shadow_top); r++) begin
      clear_shadow_cell(r, shadow_left, w, h);
      clear_shadow_cell(r, shadow_right, w, h);
    end
    for (c = int'(shadow_left) + 1; c < int'(shadow_right); c++) begin
      clear_shadow_cell(shadow_bottom, c, w, h);
      clear_shadow_cell(shadow_top, c, w, h);
    end
  endtask

  // Expected reply, if any, of one accepted input transfer.
  task automatic predict_item(input logic [1:0] func, input logic [11:0] idx,
                              input logic [VAL_W-1:0] val);
    reply_t r;
    case (func)
      FUNC_LOAD: begin
        shadow_grid[idx] = val;
        if (!cell_loaded[idx]) begin
          cell_loaded[idx] = 1'b1;
          loaded_cells = {loaded_cells, int'(idx)};
        end
      end
      FUNC_PROCESS: begin
        blur_and_clear_shadow();
        r.kind  = REPLY_DONE;
        r.value = '0;
        pending_replies = {pending_replies, r};
      end
      FUNC_READ: begin
        r.kind  = REPLY_READ;
        r.value = shadow_grid[idx];
        pending_replies = {pending_replies, r};
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return 16'h0000;
    if (r < 4)
      return 16'hFFFF;
    if (r < 5)
      return 16'(32736 + $urandom_range(0, 64));
    return 16'($urandom_range(0, 65535));
  endfunction

  // border line mostly on or just past the grid, bit 6 is don't-care noise
  function automatic logic [CFG_DATA_W-1:0] pick_border(input int span);
    int pos;
    if ($urandom_range(0, 9) < 7)
      pos = $urandom_range(0, (span > 63) ? 63 : span);
    else
      pos = $urandom_range(0, 63);
    return {1'($urandom_range(0, 1)), 6'(pos)};
  endfunction

  function automatic logic [11:0] pick_read_index(input int cells);
    if (cells > 0 && $urandom_range(0, 1) == 0)
      return 12'($urandom_range(0, cells - 1));
    return 12'(loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, every task returns just after
  // a falling edge. tvalid stays up between back-to-back transfers.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] func, input logic [11:0] idx,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap(calm_sender);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {4'b0000, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(func, idx, val);
    if (func != FUNC_UNUSED)
      items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (index)
      CFG_GRID_WIDTH:   shadow_width  = data;
      CFG_GRID_HEIGHT:  shadow_height = data;
      CFG_BORDER_LEFT:  shadow_left   = data[5:0];
      CFG_BORDER_RIGHT: shadow_right  = data[5:0];
      CFG_BORDER_BOT:   shadow_bottom = data[5:0];
      CFG_BORDER_TOP:   shadow_top    = data[5:0];
      default: ;
    endcase
  endtask

  // Block idle: no reply outstanding and any trailing load retired.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_replies.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stray traffic between the loads of a round.
  task automatic send_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      send_item(FUNC_READ, pick_read_index(0), 16'($urandom_range(0, 65535)));
    else if (r < 7)
      send_item(FUNC_LOAD, 12'($urandom_range(0, 4095)), pick_value());
    else
      send_item(FUNC_UNUSED, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
  endtask

  // One full sequence: set the grid up, load every cell in use (with noise in
  // between), process, read some cells back.
  task automatic run_blur_round(input logic [CFG_DATA_W-1:0] w_reg,
                                input logic [CFG_DATA_W-1:0] h_reg);
    int w_eff;
    int h_eff;
    int cells;
    int i;
    wait_idle();
    w_eff = (w_reg > MAX_WIDTH)  ? MAX_WIDTH  : int'(w_reg);
    h_eff = (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_reg);
    cells = w_eff * h_eff;
    write_reg(CFG_GRID_WIDTH, w_reg);
    write_reg(CFG_GRID_HEIGHT, h_reg);
    write_reg(CFG_BORDER_LEFT, pick_border(w_eff));
    write_reg(CFG_BORDER_RIGHT, pick_border(w_eff));
    write_reg(CFG_BORDER_BOT, pick_border(h_eff));
    write_reg(CFG_BORDER_TOP, pick_border(h_eff));
    calm_sender = ($urandom_range(0, 3) == 0);
    for (i = 0; i < cells; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_noise();
      send_item(FUNC_LOAD, 12'(i), pick_value());
    end
    // index and value of a process transfer are don't-care
    send_item(FUNC_PROCESS, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
    repeat ($urandom_range(1, 4))
      send_item(FUNC_READ, pick_read_index(cells), 16'($urandom_range(0, 65535)));
    calm_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // every cell_index and cell_value bit both ways, func 3 dropped
  task automatic test_load_read_extremes();
    send_item(FUNC_LOAD, 12'h000, 16'h0000);
    send_item(FUNC_LOAD, 12'hFFF, 16'hFFFF);
    send_item(FUNC_LOAD, 12'hAAA, 16'h5555);
    send_item(FUNC_LOAD, 12'h555, 16'hAAAA);
    send_item(FUNC_UNUSED, 12'h000, 16'h1234);
    send_item(FUNC_READ, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'hFFF, 16'h0000);
    send_item(FUNC_READ, 12'hAAA, 16'h0000);
    send_item(FUNC_READ, 12'h555, 16'h0000);
  endtask

  // zero width, then zero height: process touches nothing but still replies
  task automatic test_zero_size();
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd0);
    send_item(FUNC_PROCESS, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'hAAA, 16'h0000);
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd64);
    write_reg(CFG_GRID_HEIGHT, 7'd0);
    send_item(FUNC_PROCESS, 12'hFFF, 16'hFFFF);
    send_item(FUNC_READ, 12'hFFF, 16'h0000);
  endtask

  // writes to indexes 6 and 7 must not land in any register
  task automatic test_unknown_registers();
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd1);
    write_reg(CFG_GRID_HEIGHT, 7'd1);
    write_reg(CFG_BORDER_LEFT, 7'd63);
    write_reg(CFG_BORDER_RIGHT, 7'd63);
    write_reg(CFG_BORDER_BOT, 7'd63);
    write_reg(CFG_BORDER_TOP, 7'd63);
    write_reg(CFG_UNUSED_A, 7'd0);
    write_reg(CFG_UNUSED_B, 7'h7F);
    send_item(FUNC_LOAD, 12'h000, 16'hFFFF);
    send_item(FUNC_PROCESS, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'h000, 16'h0000);
  endtask

  // 1x1 grid: all neighbors are padding; lower-only replace; border lines miss the cell
  task automatic test_single_cell();
    send_item(FUNC_LOAD, 12'h000, 16'h0000);
    send_item(FUNC_PROCESS, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'h000, 16'h0000);
    send_item(FUNC_LOAD, 12'h000, 16'h7FFF);
    send_item(FUNC_PROCESS, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'h000, 16'h0000);
    wait_idle();
    write_reg(CFG_BORDER_LEFT, 7'd0);
    send_item(FUNC_LOAD, 12'h000, 16'hFFFF);
    send_item(FUNC_PROCESS, 12'h000, 16'h0000);
    send_item(FUNC_READ, 12'h000, 16'h0000);
  endtask

  // oversize clamps, full-width row and full-height column
  task automatic test_grid_extremes();
    run_blur_round(7'd127, 7'd1);
    run_blur_round(7'd1, 7'd64);
    run_blur_round(7'd64, 7'd2);
    run_blur_round(7'd2, 7'd100);
  endtask

  task automatic test_random_rounds();
    int r;
    while (items_sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        run_blur_round(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)));
      else if (r < 68)
        run_blur_round(7'($urandom_range(1, 2)), 7'd64);
      else if (r < 76)
        run_blur_round(7'd64, 7'($urandom_range(1, 2)));
      else if (r < 82)
        run_blur_round(7'($urandom_range(65, 127)), 7'd1);
      else if (r < 90)
        run_blur_round(($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(1, 8)),
                       ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(1, 8)));
      else
        run_blur_round(7'($urandom_range(7, 12)), 7'($urandom_range(7, 12)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOAD;
    cfg_we        = 1'b0;
    cfg_index     = CFG_GRID_WIDTH;
    cfg_wdata     = '0;
    errors        = 0;
    items_sent    = 0;
    cycles        = 0;
    calm_sender   = 1'b0;
    // register values after reset
    shadow_width  = 64;
    shadow_height = 64;
    shadow_left   = 0;
    shadow_right  = 63;
    shadow_bottom = 0;
    shadow_top    = 63;
    for (i = 0; i < STORE_DEPTH; i++) begin
      shadow_grid[i]    = '0;
      shadow_rowblur[i] = '0;
      cell_loaded[i]    = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_load_read_extremes();
    test_zero_size();
    test_unknown_registers();
    test_single_cell();
    test_grid_extremes();
    test_random_rounds();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls on tready, with calm stretches now and then.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall         = 0;
    calm_receiver = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0)
        calm_receiver = ~calm_receiver;
      if (stall == 0 && !calm_receiver && $urandom_range(0, 2) == 0)
        stall = pick_gap(1'b0);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Each reply transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with none expected: reply_kind %0d read_value %0h",
               m_axis_tuser[0], m_axis_tdata);
        errors++;
      end else begin
        head_reply = pending_replies.pop_front();
        if (m_axis_tuser[0] !== head_reply.kind) begin
          $error("reply_kind: expected %0d, actual %0d", head_reply.kind, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata !== head_reply.value) begin
          $error("read_value: expected %0h, actual %0h", head_reply.value, m_axis_tdata);
          errors++;
        end
      end
    end
  end

endmodule
